@@ src/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared constants, function codes and geometry type of the block pool
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned MaxPages     = 16;
  localparam int unsigned SlotsPerPage = 256;
  localparam int unsigned HeaderBytes  = 8;
  localparam int unsigned PoolSlots    = MaxPages * SlotsPerPage;

  localparam int unsigned PageW   = $clog2(MaxPages);
  localparam int unsigned SlotW   = $clog2(SlotsPerPage);
  localparam int unsigned HandleW = PageW + SlotW;

  localparam int unsigned DataSizeW = 17;
  localparam int unsigned AlignW    = 4;
  localparam int unsigned PageSizeW = 21;
  localparam int unsigned BlkW      = 18;
  localparam int unsigned PerPageW  = SlotW + 1;
  localparam int unsigned AddrW     = 24;
  localparam int unsigned CountW    = 13;
  localparam int unsigned PagesW    = 5;

  // function codes
  localparam logic [1:0] FuncAlloc   = 2'd0;
  localparam logic [1:0] FuncFree    = 2'd1;
  localparam logic [1:0] FuncFreeAll = 2'd2;

  // register indexes
  localparam logic [1:0] RegDataSize = 2'd0;
  localparam logic [1:0] RegAlignLog = 2'd1;
  localparam logic [1:0] RegPageSize = 2'd2;

  typedef struct packed {
    logic [BlkW-1:0]     blk_bytes;
    logic [PerPageW-1:0] per_page;
  } geom_t;

endpackage

@@ src/fbpa_geom.sv @@
// ----------------------------------------------------------------------------
// fbpa_geom
// block size and blocks-per-page, worked out by a shared compare/subtract unit
// ----------------------------------------------------------------------------
module fbpa_geom
  import fbpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DataSizeW-1:0] data_size_i,
  input  logic [AlignW-1:0]    align_log2_i,
  input  logic [PageSizeW-1:0] page_size_i,
  output logic                 busy_o,
  output geom_t                geom_o
);

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_PREP = 3'b010,
    G_DIV  = 3'b100
  } geom_state_e;

  localparam int unsigned TrialW = BlkW + SlotW + 1;
  localparam int unsigned BitW   = $clog2(SlotW + 1);

  geom_state_e           state_q, state_d;
  logic [BlkW-1:0]       blk_q, blk_d;
  logic [PerPageW-1:0]   quo_q, quo_d;
  logic [PageSizeW-1:0]  rem_q, rem_d;
  logic [BitW-1:0]       bit_q, bit_d;

  logic [DataSizeW-1:0]  need;
  logic [BlkW-1:0]       mask;
  logic [TrialW-1:0]     trial;
  logic                  fits;

  always_comb begin
    need  = (data_size_i > DataSizeW'(HeaderBytes)) ? data_size_i : DataSizeW'(HeaderBytes);
    mask  = (BlkW'(1) << align_log2_i) - BlkW'(1);
    trial = TrialW'(blk_q) << bit_q;
    fits  = TrialW'(rem_q) >= trial;
  end

  always_comb begin
    state_d = state_q;
    blk_d   = blk_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    case (state_q)
      G_IDLE: ;
      G_PREP: begin
        blk_d   = (BlkW'(need) + mask) & ~mask;
        rem_d   = (page_size_i >= PageSizeW'(HeaderBytes)) ?
                  page_size_i - PageSizeW'(HeaderBytes) : '0;
        quo_d   = '0;
        bit_d   = BitW'(SlotW);
        state_d = G_DIV;
      end
      G_DIV: begin
        if (bit_q == BitW'(SlotW)) begin
          // quotient at or above the cap
          if (fits) begin
            quo_d   = PerPageW'(SlotsPerPage);
            state_d = G_IDLE;
          end else begin
            bit_d = bit_q - BitW'(1);
          end
        end else begin
          if (fits) begin
            rem_d        = rem_q - trial[PageSizeW-1:0];
            quo_d[bit_q] = 1'b1;
          end
          if (bit_q == '0) begin
            state_d = G_IDLE;
          end else begin
            bit_d = bit_q - BitW'(1);
          end
        end
      end
      default: state_d = G_IDLE;
    endcase
    if (start_i) begin
      state_d = G_PREP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      blk_q   <= BlkW'(HeaderBytes);
      quo_q   <= PerPageW'(SlotsPerPage);
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
      quo_q   <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    bit_q <= bit_d;
  end

  assign busy_o           = (state_q != G_IDLE);
  assign geom_o.blk_bytes = blk_q;
  assign geom_o.per_page  = quo_q;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// pool of equal-sized blocks carved from up to sixteen pages
// ----------------------------------------------------------------------------
// a request is taken when start_i is high and busy_o is low; its result is
// shown for exactly one cycle with valid_o high and there is no back-pressure,
// so the receiver must take every transfer as it comes. free, free-all and
// no-op answer in the cycle after the request without raising busy_o.
// an allocate that fails answers the same way. an allocate from a fresh page
// slot keeps busy_o high through S_MUL (address products) and S_ADD (the sum)
// and answers with the registered sum; an allocate popped from the free list
// first passes S_POP for the synchronous read of the link memory. a write to a
// mapped register empties the pool and raises busy_o while the block size and
// the blocks per page are recomputed by an iterative divider, one quotient bit
// a cycle. page_count_o, block_count_o and free_count_o track the pool
// state and hold their value for the result transfer
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           func_i,
  input  logic [HandleW-1:0]   free_handle_i,
  // result
  output logic                 valid_o,
  output logic                 status_o,
  output logic [HandleW-1:0]   block_handle_o,
  output logic [AddrW-1:0]     block_address_o,
  output logic [PagesW-1:0]    page_count_o,
  output logic [CountW-1:0]    block_count_o,
  output logic [CountW-1:0]    free_count_o,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [PageSizeW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_MUL  = 4'b0100,
    S_ADD  = 4'b1000
  } state_e;

  localparam int unsigned LinkW = HandleW + 1;

  // configuration registers
  logic [DataSizeW-1:0] data_size_q;
  logic [AlignW-1:0]    align_q;
  logic [PageSizeW-1:0] page_size_q;
  logic                 cfg_hit;

  geom_t geom;
  logic  geom_busy;

  // pool state
  state_e              state_q, state_d;
  logic [LinkW-1:0]    head_q, head_d;
  logic [PerPageW-1:0] fresh_q, fresh_d;
  logic [PagesW-1:0]   pages_q, pages_d;
  logic [CountW-1:0]   total_q, total_d;
  logic [CountW-1:0]   free_q, free_d;

  // working registers of one allocate
  logic [PageW-1:0]    page_q, page_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [AddrW-1:0]    prod_a_q, prod_b_q;

  // result registers
  logic                valid_q, valid_d;
  logic                status_q, status_d;
  logic [HandleW-1:0]  handle_q, handle_d;
  logic [AddrW-1:0]    addr_q, addr_d;

  // link memory
  logic [LinkW-1:0]    link_mem [PoolSlots];
  logic [LinkW-1:0]    link_rd_q;
  logic                link_we;

  logic                accept;
  logic [PageW-1:0]    req_page;
  logic [SlotW-1:0]    req_slot;
  logic [PagesW-1:0]   last_page;
  logic                free_ok;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == RegDataSize || cfg_idx_i == RegAlignLog ||
                                cfg_idx_i == RegPageSize);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_size_q <= DataSizeW'(8);
      align_q     <= AlignW'(3);
      page_size_q <= PageSizeW'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDataSize: data_size_q <= cfg_data_i[DataSizeW-1:0];
        RegAlignLog: align_q     <= cfg_data_i[AlignW-1:0];
        RegPageSize: page_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the geometry recompute is started from the new register values in the cycle after the write
  logic geom_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_start_q <= 1'b0;
    end else begin
      geom_start_q <= cfg_hit;
    end
  end

  fbpa_geom u_geom (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (geom_start_q),
    .data_size_i  (data_size_q),
    .align_log2_i (align_q),
    .page_size_i  (page_size_q),
    .busy_o       (geom_busy),
    .geom_o       (geom)
  );

  assign busy_o = (state_q != S_IDLE) || geom_busy || geom_start_q;
  assign accept = start_i && !busy_o;

  // free-handle checks
  assign req_page  = free_handle_i[HandleW-1:SlotW];
  assign req_slot  = free_handle_i[SlotW-1:0];
  assign last_page = pages_q - PagesW'(1);
  assign free_ok   = (PagesW'(req_page) < pages_q)
                  && (PerPageW'(req_slot) < geom.per_page)
                  && !((PagesW'(req_page) == last_page) && (PerPageW'(req_slot) >= fresh_q))
                  && (free_q < total_q);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    fresh_d  = fresh_q;
    pages_d  = pages_q;
    total_d  = total_q;
    free_d   = free_q;
    page_d   = page_q;
    slot_d   = slot_q;
    valid_d  = 1'b0;
    status_d = status_q;
    handle_d = handle_q;
    addr_d   = addr_q;
    link_we  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = 1'b0;
          handle_d = '0;
          addr_d   = '0;
          case (func_i)
            FuncAlloc: begin
              if (!head_q[HandleW]) begin
                // pop the free list, the next link arrives from memory
                page_d  = head_q[HandleW-1:SlotW];
                slot_d  = head_q[SlotW-1:0];
                free_d  = free_q - CountW'(1);
                state_d = S_POP;
              end else if (pages_q != '0 && fresh_q < geom.per_page) begin
                page_d  = last_page[PageW-1:0];
                slot_d  = fresh_q[SlotW-1:0];
                fresh_d = fresh_q + PerPageW'(1);
                free_d  = free_q - CountW'(1);
                state_d = S_MUL;
              end else if (pages_q < PagesW'(MaxPages) && geom.per_page != '0) begin
                // open a new page and hand out its first slot
                page_d  = pages_q[PageW-1:0];
                slot_d  = '0;
                fresh_d = PerPageW'(1);
                pages_d = pages_q + PagesW'(1);
                total_d = total_q + CountW'(geom.per_page);
                free_d  = free_q + CountW'(geom.per_page) - CountW'(1);
                state_d = S_MUL;
              end else begin
                status_d = 1'b1;
                valid_d  = 1'b1;
              end
            end
            FuncFree: begin
              if (free_ok) begin
                link_we = 1'b1;
                head_d  = LinkW'(free_handle_i);
                free_d  = free_q + CountW'(1);
              end
              valid_d = 1'b1;
            end
            FuncFreeAll: begin
              head_d  = LinkW'(PoolSlots);
              fresh_d = '0;
              pages_d = '0;
              total_d = '0;
              free_d  = '0;
              valid_d = 1'b1;
            end
            default: valid_d = 1'b1;
          endcase
        end
      end
      S_POP: begin
        head_d  = link_rd_q;
        state_d = S_MUL;
      end
      S_MUL: state_d = S_ADD;
      S_ADD: begin
        handle_d = {page_q, slot_q};
        addr_d   = prod_a_q + prod_b_q + AddrW'(HeaderBytes);
        valid_d  = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // a register write changes the geometry, so the pool is emptied
    if (cfg_hit) begin
      head_d  = LinkW'(PoolSlots);
      fresh_d = '0;
      pages_d = '0;
      total_d = '0;
      free_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= LinkW'(PoolSlots);
      fresh_q <= '0;
      pages_q <= '0;
      total_q <= '0;
      free_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fresh_q <= fresh_d;
      pages_q <= pages_d;
      total_q <= total_d;
      free_q  <= free_d;
      valid_q <= valid_d;
    end
  end

  // address products, each registered before the final sum
  always_ff @(posedge clk_i) begin
    page_q   <= page_d;
    slot_q   <= slot_d;
    status_q <= status_d;
    handle_q <= handle_d;
    addr_q   <= addr_d;
    if (state_q == S_MUL) begin
      prod_a_q <= AddrW'((PageSizeW + PageW)'(page_q) * (PageSizeW + PageW)'(page_size_q));
      prod_b_q <= AddrW'((BlkW + SlotW)'(slot_q) * (BlkW + SlotW)'(geom.blk_bytes));
    end
  end

  // link memory: one write port for free, one registered read at the head
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[free_handle_i] <= head_q;
    end
    link_rd_q <= link_mem[head_q[HandleW-1:0]];
  end

  assign valid_o         = valid_q;
  assign status_o        = status_q;
  assign block_handle_o  = handle_q;
  assign block_address_o = addr_q;
  assign page_count_o    = pages_q;
  assign block_count_o   = total_q;
  assign free_count_o    = free_q;

endmodule

@@ bench/fbpa_pool_check.sv @@
// ----------------------------------------------------------------------------
// fbpa_pool_check
// watches the request, result and register ports of the block pool, keeps its
// own copy of the pool and compares every result transfer with the oldest
// predicted one
// ----------------------------------------------------------------------------
module fbpa_pool_check
  import fbpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [1:0]           func_i,
  input  logic [HandleW-1:0]   free_handle_i,
  input  logic                 valid_i,
  input  logic                 status_i,
  input  logic [HandleW-1:0]   handle_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic [PagesW-1:0]    pages_i,
  input  logic [CountW-1:0]    blocks_i,
  input  logic [CountW-1:0]    free_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [PageSizeW-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               status;
    logic [HandleW-1:0] handle;
    logic [AddrW-1:0]   addr;
    logic [PagesW-1:0]  pages;
    logic [CountW-1:0]  blocks;
    logic [CountW-1:0]  free_blocks;
  } pool_result_t;

  logic [DataSizeW-1:0] data_size_q;
  logic [AlignW-1:0]    align_log_q;
  logic [PageSizeW-1:0] page_size_q;
  longint unsigned      blk_bytes;
  int unsigned          per_page;

  logic [CountW-1:0] link_mem [PoolSlots];
  int unsigned       list_head;
  int unsigned       fresh_slot;
  int unsigned       pages_held;
  int unsigned       blocks_total;
  int unsigned       blocks_free;

  pool_result_t awaited_results [$];
  int           mismatches;

  function automatic void recompute_geometry();
    longint unsigned need;
    longint unsigned align;
    longint unsigned n;
    need = (data_size_q > HeaderBytes) ? longint'(data_size_q) : longint'(HeaderBytes);
    align = 64'd1 << align_log_q;
    blk_bytes = (need + align - 1) & ~(align - 1);
    if (page_size_q < HeaderBytes) n = 0;
    else n = (longint'(page_size_q) - HeaderBytes) / blk_bytes;
    if (n > SlotsPerPage) n = SlotsPerPage;
    per_page = int'(n);
  endfunction

  function automatic void empty_pool();
    list_head    = PoolSlots;
    fresh_slot   = 0;
    pages_held   = 0;
    blocks_total = 0;
    blocks_free  = 0;
  endfunction

  function automatic void write_register(input logic [1:0] idx,
                                         input logic [PageSizeW-1:0] data);
    case (idx)
      RegDataSize: data_size_q = data[DataSizeW-1:0];
      RegAlignLog: align_log_q = data[AlignW-1:0];
      RegPageSize: page_size_q = data;
      default: return;
    endcase
    // new geometry, so every page is given back
    empty_pool();
    recompute_geometry();
  endfunction

  function automatic void serve_request(input logic [1:0] func,
                                        input logic [HandleW-1:0] req);
    pool_result_t    r;
    int unsigned     page;
    int unsigned     slot;
    int unsigned     h;
    bit              ok;
    bit              good;
    longint unsigned addr;
    r = '0;
    if (func == FuncAlloc) begin
      ok = 1'b1;
      page = 0;
      slot = 0;
      if (list_head < PoolSlots) begin
        // pop the most recently freed block
        h = list_head;
        list_head = link_mem[h];
        page = h / SlotsPerPage;
        slot = h % SlotsPerPage;
      end else if (pages_held > 0 && fresh_slot < per_page) begin
        page = pages_held - 1;
        slot = fresh_slot;
        fresh_slot++;
      end else if (pages_held < MaxPages && per_page > 0) begin
        page = pages_held;
        pages_held++;
        blocks_total += per_page;
        blocks_free  += per_page;
        slot = 0;
        fresh_slot = 1;
      end else begin
        ok = 1'b0;
      end
      if (ok) begin
        blocks_free--;
        addr = longint'(page) * page_size_q + HeaderBytes + longint'(slot) * blk_bytes;
        r.handle = HandleW'(page * SlotsPerPage + slot);
        r.addr = addr[AddrW-1:0];
      end else begin
        r.status = 1'b1;
      end
    end else if (func == FuncFree) begin
      page = req / SlotsPerPage;
      slot = req % SlotsPerPage;
      good = page < pages_held && slot < per_page
          && !(page == pages_held - 1 && slot >= fresh_slot)
          && blocks_free < blocks_total;
      if (good) begin
        link_mem[req] = list_head[CountW-1:0];
        list_head = req;
        blocks_free++;
      end
    end else if (func == FuncFreeAll) begin
      empty_pool();
    end
    r.pages       = pages_held[PagesW-1:0];
    r.blocks      = blocks_total[CountW-1:0];
    r.free_blocks = blocks_free[CountW-1:0];
    awaited_results.push_back(r);
  endfunction

  function automatic void check_result(input pool_result_t got);
    pool_result_t want;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result transfer with nothing pending: status=%0d handle=%0h",
                 $realtime, got.status, got.handle);
      return;
    end
    want = awaited_results.pop_front();
    if (want.status !== got.status || want.handle !== got.handle
        || want.addr !== got.addr || want.pages !== got.pages
        || want.blocks !== got.blocks || want.free_blocks !== got.free_blocks) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: mismatch, expected status=%0d handle=%0h addr=%0h pages=%0d ",
                  "blocks=%0d free=%0d, got status=%0d handle=%0h addr=%0h pages=%0d ",
                  "blocks=%0d free=%0d"},
                 $realtime, want.status, want.handle, want.addr, want.pages,
                 want.blocks, want.free_blocks, got.status, got.handle, got.addr,
                 got.pages, got.blocks, got.free_blocks);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_size_q = 17'd8;
      align_log_q = 4'd3;
      page_size_q = 21'd4096;
      empty_pool();
      recompute_geometry();
      awaited_results.delete();
      mismatches = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // retire first so a result never meets its own request's expectation
      if (valid_i)
        check_result('{status_i, handle_i, address_i, pages_i, blocks_i, free_i});
      if (cfg_we_i) write_register(cfg_idx_i, cfg_data_i);
      if (start_i && !busy_i) serve_request(func_i, free_handle_i);
      fail_count_o  <= mismatches;
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

@@ bench/fixed_block_pool_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// drives allocate, free, free-all and no-op requests into the block pool under
// a range of block geometries, with random gaps between requests, and takes
// the verdict from the pool checker that runs beside the block
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbpa_pkg::*;

  // function code with no operation behind it, and the register index that
  // has no register behind it
  localparam logic [1:0] FuncNop  = 2'd3;
  localparam logic [1:0] RegSpare = 2'd3;

  localparam int CycleLimit  = 400000;
  localparam int PhaseCount  = 12;
  localparam int PhaseItems  = 108;
  localparam int DirectCount = 20;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [1:0]           func_i = FuncNop;
  logic [HandleW-1:0]   free_handle_i = '0;
  logic                 valid_o;
  logic                 status_o;
  logic [HandleW-1:0]   block_handle_o;
  logic [AddrW-1:0]     block_address_o;
  logic [PagesW-1:0]    page_count_o;
  logic [CountW-1:0]    block_count_o;
  logic [CountW-1:0]    free_count_o;
  logic                 cfg_we_i = 1'b0;
  logic [1:0]           cfg_idx_i = RegDataSize;
  logic [PageSizeW-1:0] cfg_data_i = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;

  // handles the pool has handed out and not yet had back, used to build
  // well-formed free requests
  logic [HandleW-1:0] live_handles [$];
  logic [HandleW-1:0] last_freed = '0;

  // fixed geometries: defaults, one block per page, large blocks and pages,
  // a page smaller than its header, and a few in between
  int unsigned geo_data  [8] = '{8, 1, 65536, 100, 8, 24, 1000, 12};
  int unsigned geo_align [8] = '{3, 0, 12, 5, 0, 4, 12, 2};
  int unsigned geo_page  [8] = '{4096, 16, 1048576, 1000, 4, 200, 1048576, 60};

  // opening sequence under the reset geometry
  logic [1:0] dir_func [DirectCount] = '{
    FuncAlloc, FuncAlloc, FuncAlloc, FuncFree, FuncFree,
    FuncAlloc, FuncAlloc, FuncFree, FuncFree, FuncFree,
    FuncNop, FuncFreeAll, FuncFree, FuncAlloc, FuncFree,
    FuncFree, FuncAlloc, FuncAlloc, FuncFree, FuncFree
  };
  logic [HandleW-1:0] dir_handle [DirectCount] = '{
    12'hfff, 12'h000, 12'h000, 12'h001, 12'h001,   // free twice, then two pops
    12'h000, 12'h000, 12'hfff, 12'h005, 12'h100,   // page not held, past cursor
    12'h000, 12'h000, 12'h000, 12'h000, 12'h000,   // free on empty pool
    12'h000, 12'h000, 12'h000, 12'haaa, 12'h555    // free with every block free
  };

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  fixed_block_pool_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .free_handle_i   (free_handle_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .block_handle_o  (block_handle_o),
    .block_address_o (block_address_o),
    .page_count_o    (page_count_o),
    .block_count_o   (block_count_o),
    .free_count_o    (free_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  fbpa_pool_check u_pool_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .func_i        (func_i),
    .free_handle_i (free_handle_i),
    .valid_i       (valid_o),
    .status_i      (status_o),
    .handle_i      (block_handle_o),
    .address_i     (block_address_o),
    .pages_i       (page_count_o),
    .blocks_i      (block_count_o),
    .free_i        (free_count_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[fixed_block_pool_allocator] ERROR");
      $finish;
    end
  end

  // a successful allocate is the only transfer with a non-zero address
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !status_o && block_address_o != '0)
      live_handles.push_back(block_handle_o);
  end

  // one request transfer; start_i stays high afterwards so that a request
  // with no gap follows on the very next edge
  task automatic send_request(input logic [1:0] func, input logic [HandleW-1:0] handle,
                              input int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    func_i        <= func;
    free_handle_i <= handle;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // drop start_i and let every pending result come back before going on
  task automatic settle_pool();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, then wait out the geometry recompute
  task automatic write_register(input logic [1:0] idx, input int unsigned data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[PageSizeW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // mostly allocate and give back what was handed out, with stray handles,
  // double frees, no-ops and the odd free-all as noise
  task automatic run_phase(input int unsigned alloc_pct, input bit burst);
    int unsigned roll;
    int unsigned gap;
    int unsigned pick;
    logic [HandleW-1:0] h;
    repeat (PhaseItems) begin
      roll = $urandom_range(0, 99);
      gap  = burst ? 0 : $urandom_range(0, 17);
      if (roll < alloc_pct) begin
        send_request(FuncAlloc, HandleW'($urandom), gap);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 72 && live_handles.size() != 0) begin
          pick = $urandom_range(0, live_handles.size() - 1);
          h = live_handles[pick];
          live_handles.delete(pick);
          last_freed = h;
          send_request(FuncFree, h, gap);
        end else if (roll < 80) begin
          send_request(FuncFree, last_freed, gap);
        end else if (roll < 91) begin
          send_request(FuncFree, HandleW'($urandom_range(0, PoolSlots - 1)), gap);
        end else if (roll < 97) begin
          send_request(FuncNop, HandleW'($urandom), gap);
        end else begin
          live_handles.delete();
          send_request(FuncFreeAll, HandleW'($urandom), gap);
        end
      end
    end
  endtask

  initial begin
    int unsigned data_size;
    int unsigned align_log;
    int unsigned page_size;
    bit          burst;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // opening sequence under the reset geometry
    for (int i = 0; i < DirectCount; i++)
      send_request(dir_func[i], dir_handle[i], $urandom_range(0, 17));

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase != 0) begin
        settle_pool();
        live_handles.delete();
        if (phase < 8) begin
          data_size = geo_data[phase];
          align_log = geo_align[phase];
          page_size = geo_page[phase];
        end else if (phase < PhaseCount - 1) begin
          data_size = $urandom_range(1, 300);
          align_log = $urandom_range(0, 12);
          page_size = $urandom_range(16, 4000);
        end else begin
          data_size = $urandom_range(1, 65536);
          align_log = $urandom_range(0, 12);
          page_size = $urandom_range(16, 1048576);
        end
        // unmapped index must leave the pool alone
        if (phase == 1) write_register(RegSpare, $urandom);
        write_register(RegDataSize, data_size);
        write_register(RegAlignLog, align_log);
        write_register(RegPageSize, page_size);
      end
      burst = (phase % 4 == 2) || ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(45, 80), burst);
    end

    settle_pool();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[fixed_block_pool_allocator] OK");
    end else begin
      $display("[fixed_block_pool_allocator] ERROR");
    end
    $finish;
  end

endmodule
